[hw/rtl/lcar_pkg.sv]
// shared types and constants for the load cell readout and averager
// no dependencies

package lcar_pkg;

  localparam int DATA_BITS  = 24;
  localparam int SUM_W      = 27;
  localparam int HALF_W     = 16;
  localparam int TMO_W      = 32;
  localparam int TARE_W     = 24;
  localparam int GAIN_W     = 32;
  localparam int WEIGHT_W   = 31;
  localparam int BIT_IDX_W  = 5;
  localparam int SMP_IDX_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARE        = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd3;

  localparam logic [HALF_W-1:0] HALF_RST = 16'd100;
  localparam logic [TMO_W-1:0]  TMO_RST  = 32'd10000000;
  localparam logic [TARE_W-1:0] TARE_RST = 24'h800000;
  localparam logic [GAIN_W-1:0] GAIN_RST = 32'h00010000;

  localparam logic [DATA_BITS-1:0] SIGN_FLIP = 24'h800000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DIV,
    C_MUL,
    C_SAT
  } calc_e;

  typedef struct packed {
    logic sck;
    logic busy;
    logic done;
    logic status;
    logic calc;
  } tick_res_t;

endpackage

[hw/rtl/load_cell_adc_reader_averager_top.sv]
// One input item is one system tick carrying start_req_i and the data pin
// level; each accepted item yields exactly one result item with the serial
// clock level, busy, done, status and weight. The tick that completes a good
// weighing runs the bit-serial divide by the sample count, the tare subtract,
// the shift-add gain multiply and saturation, during which no item is
// accepted. When the average does not exceed the tare the multiply is
// skipped. A result waiting at the output does not stop the next item when
// the consumer takes it in the same cycle.
// depends on lcar_pkg, lcar_ctrl, lcar_wcalc

module load_cell_adc_reader_averager_top import lcar_pkg::*; #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   start_req_i,
  input  logic                   dt_level_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   sck_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic                   status_o,
  output logic [WEIGHT_W-1:0]    weight_mg_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i
);

  logic [HALF_W-1:0]   half_q;
  logic [TMO_W-1:0]    tmo_q;
  logic [TARE_W-1:0]   tare_q;
  logic [GAIN_W-1:0]   gain_q;

  tick_res_t           res;
  logic [SUM_W-1:0]    sum;
  logic                accept;
  logic                calc_busy;
  logic                calc_done;
  logic [WEIGHT_W-1:0] calc_weight;

  logic                out_valid_q;
  tick_res_t           out_res_q;
  logic [WEIGHT_W-1:0] weight_q;

  assign in_ready_o = (!out_valid_q || out_ready_i) && !calc_busy;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_RST;
      tmo_q  <= TMO_RST;
      tare_q <= TARE_RST;
      gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_PERIOD: half_q <= cfg_wdata_i[HALF_W-1:0];
        REG_TIMEOUT:     tmo_q  <= cfg_wdata_i[TMO_W-1:0];
        REG_TARE:        tare_q <= cfg_wdata_i[TARE_W-1:0];
        REG_GAIN:        gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lcar_ctrl #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_en_i     (accept),
    .start_i       (start_req_i),
    .dt_i          (dt_level_i),
    .half_period_i (half_q),
    .timeout_i     (tmo_q),
    .res_o         (res),
    .sum_o         (sum)
  );

  lcar_wcalc #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_wcalc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept && res.calc),
    .sum_i    (sum),
    .tare_i   (tare_q),
    .gain_i   (gain_q),
    .busy_o   (calc_busy),
    .done_o   (calc_done),
    .weight_o (calc_weight)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (calc_done) begin
      out_valid_q <= 1'b1;
    end else if (accept) begin
      out_valid_q <= !res.calc;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= res;
      weight_q  <= '0;
    end else if (calc_done) begin
      weight_q  <= calc_weight;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sck_o       = out_res_q.sck;
  assign busy_res_o  = out_res_q.busy;
  assign done_res_o  = out_res_q.done;
  assign status_o    = out_res_q.status;
  assign weight_mg_o = weight_q;

  a_weight_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (weight_mg_o != '0) |-> done_res_o && !status_o)
    else $error("weight present without a good finish");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("finished item still flagged busy");

  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> done_res_o)
    else $error("error status outside a finish");

  a_calc_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |=> out_valid_o && done_res_o)
    else $error("weight result not presented after calculation");

  a_calc_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_busy && !calc_done |-> !out_valid_o)
    else $error("item presented while weight still computing");

endmodule

[hw/rtl/lcar_ctrl.sv]
// tick sequencer: ready wait, serial clock generation, bit capture and summing
// depends on lcar_pkg

module lcar_ctrl import lcar_pkg::*; #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_en_i,
  input  logic                  start_i,
  input  logic                  dt_i,
  input  logic [HALF_W-1:0]     half_period_i,
  input  logic [TMO_W-1:0]      timeout_i,
  output tick_res_t             res_o,
  output logic [SUM_W-1:0]      sum_o
);

  phase_e                 phase_q, phase_d;
  logic [HALF_W-1:0]      htc_q, htc_d;
  logic [TMO_W-1:0]       wait_q, wait_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [DATA_BITS-1:0]   word_q, word_d;
  logic [SMP_IDX_W-1:0]   sidx_q, sidx_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   sck_q, sck_d;

  logic [HALF_W-1:0]      hp;
  logic                   half_over;
  logic [TMO_W-1:0]       lim_m1;
  logic [DATA_BITS-1:0]   w;
  logic                   more_bits;

  assign hp        = (half_period_i == '0) ? HALF_W'(1) : half_period_i;
  assign half_over = ({1'b0, htc_q} + (HALF_W+1)'(1)) >= {1'b0, hp};
  assign lim_m1    = (timeout_i == '0) ? '0 : timeout_i - TMO_W'(1);
  assign w         = word_q ^ SIGN_FLIP;
  assign more_bits = bit_q < BIT_IDX_W'(DATA_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      htc_q   <= '0;
      wait_q  <= '0;
      bit_q   <= '0;
      word_q  <= '0;
      sidx_q  <= '0;
      sum_q   <= '0;
      sck_q   <= 1'b0;
    end else if (tick_en_i) begin
      phase_q <= phase_d;
      htc_q   <= htc_d;
      wait_q  <= wait_d;
      bit_q   <= bit_d;
      word_q  <= word_d;
      sidx_q  <= sidx_d;
      sum_q   <= sum_d;
      sck_q   <= sck_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    htc_d   = htc_q;
    wait_d  = wait_q;
    bit_d   = bit_q;
    word_d  = word_q;
    sidx_d  = sidx_q;
    sum_d   = sum_q;
    sck_d   = sck_q;
    res_o   = '0;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_WAIT;
          wait_d  = '0;
          sidx_d  = '0;
          sum_d   = '0;
          sck_d   = 1'b0;
        end
      end
      PH_WAIT: begin
        if (!dt_i) begin
          phase_d = PH_HIGH;
          sck_d   = 1'b1;
          htc_d   = '0;
          bit_d   = '0;
          word_d  = '0;
        end else if (wait_q >= lim_m1) begin
          phase_d      = PH_IDLE;
          res_o.done   = 1'b1;
          res_o.status = 1'b1;
        end else begin
          wait_d = wait_q + TMO_W'(1);
        end
      end
      PH_HIGH: begin
        if (half_over) begin
          if (more_bits) begin
            word_d = {word_q[DATA_BITS-2:0], 1'b0};
          end
          sck_d   = 1'b0;
          htc_d   = '0;
          phase_d = PH_LOW;
        end else begin
          htc_d = htc_q + HALF_W'(1);
        end
      end
      PH_LOW: begin
        if (!half_over) begin
          htc_d = htc_q + HALF_W'(1);
        end else begin
          htc_d = '0;
          if (more_bits) begin
            word_d  = {word_q[DATA_BITS-1:1], dt_i};
            bit_d   = bit_q + BIT_IDX_W'(1);
            sck_d   = 1'b1;
            phase_d = PH_HIGH;
          end else if (w == '0) begin
            phase_d      = PH_IDLE;
            res_o.done   = 1'b1;
            res_o.status = 1'b1;
          end else begin
            sum_d  = sum_q + SUM_W'(w);
            sidx_d = sidx_q + SMP_IDX_W'(1);
            if (sidx_d >= SMP_IDX_W'(SAMPLE_COUNT)) begin
              phase_d    = PH_IDLE;
              res_o.done = 1'b1;
              res_o.calc = 1'b1;
            end else begin
              phase_d = PH_WAIT;
              wait_d  = '0;
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    res_o.sck  = sck_d;
    res_o.busy = (phase_d != PH_IDLE);
  end

  assign sum_o = sum_d;

endmodule

[hw/rtl/lcar_wcalc.sv]
// weight unit: bit-serial divide by sample count, tare subtract,
// shift-add gain multiply and saturation; depends on lcar_pkg

module lcar_wcalc import lcar_pkg::*; #(
  parameter int SAMPLE_COUNT = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [SUM_W-1:0]     sum_i,
  input  logic [TARE_W-1:0]    tare_i,
  input  logic [GAIN_W-1:0]    gain_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [WEIGHT_W-1:0]  weight_o
);

  localparam int PROD_W = DATA_BITS + GAIN_W;
  localparam int CNT_W  = 5;
  localparam int DVS_W  = 3;
  localparam int SAT_HI = PROD_W - 1;
  localparam int SAT_LO = 16 + WEIGHT_W;

  localparam logic [DVS_W-1:0] DIVISOR = DVS_W'(SAMPLE_COUNT);

  calc_e               state_q, state_d;
  logic [SUM_W-1:0]    num_q, num_d;
  logic [DVS_W-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0]   prod_q, prod_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;

  logic [DVS_W:0]      trial;
  logic                ge;
  logic [GAIN_W:0]     psum;

  assign trial = {rem_q, num_q[SUM_W-1]};
  assign ge    = trial >= {1'b0, DIVISOR};
  assign psum  = {1'b0, prod_q[PROD_W-1:DATA_BITS]} + (prod_q[0] ? {1'b0, gain_i} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    state_d  = state_q;
    num_d    = num_q;
    rem_d    = rem_q;
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    done_o   = 1'b0;
    weight_o = '0;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          num_d   = sum_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = C_DIV;
        end
      end
      C_DIV: begin
        if (cnt_q == CNT_W'(SUM_W)) begin
          // quotient complete, subtract tare
          cnt_d = '0;
          if (num_q <= SUM_W'(tare_i)) begin
            prod_d  = '0;
            state_d = C_SAT;
          end else begin
            prod_d  = {GAIN_W'(0), DATA_BITS'(num_q - SUM_W'(tare_i))};
            state_d = C_MUL;
          end
        end else begin
          rem_d = ge ? DVS_W'(trial - {1'b0, DIVISOR}) : trial[DVS_W-1:0];
          num_d = {num_q[SUM_W-2:0], ge};
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      C_MUL: begin
        prod_d = {psum, prod_q[DATA_BITS-1:1]};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DATA_BITS - 1)) begin
          state_d = C_SAT;
        end
      end
      C_SAT: begin
        done_o   = 1'b1;
        weight_o = (prod_q[SAT_HI:SAT_LO] != '0) ? '1 : prod_q[SAT_LO-1:16];
        state_d  = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != C_IDLE);

endmodule
